/* design/ir_pulse_distance_decoder_core_defines.svh */
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder_core_defines
// assertion macros used by the decoder core rtl
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_DISTANCE_DECODER_CORE_DEFINES_SVH
`define IR_PULSE_DISTANCE_DECODER_CORE_DEFINES_SVH

// checked property, masked while reset is held
`define IRPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked property that also holds across reset
`define IRPD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* design/irpd_pkg.sv */
// ----------------------------------------------------------------------------
// irpd_pkg
// types and constants of the ir pulse distance decoder
// ----------------------------------------------------------------------------
`default_nettype none

package irpd_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_START_LOW  = 3'd0,
        REG_START_HIGH = 3'd1,
        REG_ZERO_LOW   = 3'd2,
        REG_BIT_SPLIT  = 3'd3,
        REG_ONE_HIGH   = 3'd4
    } cfg_reg_t;

    // reset values of the window bounds, in timer ticks
    localparam logic [15:0] START_LOW_RST  = 16'd8000;
    localparam logic [15:0] START_HIGH_RST = 16'd14000;
    localparam logic [15:0] ZERO_LOW_RST   = 16'd700;
    localparam logic [15:0] BIT_SPLIT_RST  = 16'd1450;
    localparam logic [15:0] ONE_HIGH_RST   = 16'd3000;

    // key codes
    localparam logic [7:0] CMD_FORWARD    = 8'h18;
    localparam logic [7:0] CMD_REVERSE    = 8'h52;
    localparam logic [7:0] CMD_TURN_LEFT  = 8'h08;
    localparam logic [7:0] CMD_TURN_RIGHT = 8'h5A;
    localparam logic [7:0] CMD_STOP       = 8'h1C;

    typedef enum logic [1:0] {
        DRV_STOP = 2'd0,
        DRV_FWD  = 2'd1,
        DRV_REV  = 2'd2
    } drive_t;

    typedef struct packed {
        logic [15:0] start_low;
        logic [15:0] start_high;
        logic [15:0] zero_low;
        logic [15:0] bit_split;
        logic [15:0] one_high;
    } win_cfg_t;

    typedef struct packed {
        logic is_start;
        logic is_one;
        logic is_zero;
    } win_hit_t;

    typedef struct packed {
        logic        frame_done;
        logic        frame_ok;
        logic [15:0] address_word;
        logic [7:0]  command_byte;
        drive_t      left_drive;
        drive_t      right_drive;
    } result_t;

endpackage

`default_nettype wire

/* design/irpd_window.sv */
// ----------------------------------------------------------------------------
// irpd_window
// sorts one edge interval into the start, one and zero windows
// ----------------------------------------------------------------------------
`default_nettype none

module irpd_window import irpd_pkg::*; (
    input  wire logic [15:0] edge_interval,
    input  wire win_cfg_t    win_cfg,
    output win_hit_t         win_hit
);

    // all bounds are exclusive
    always_comb begin
        win_hit.is_start = (edge_interval > win_cfg.start_low) &&
                           (edge_interval < win_cfg.start_high);
        win_hit.is_one   = (edge_interval > win_cfg.bit_split) &&
                           (edge_interval < win_cfg.one_high);
        win_hit.is_zero  = (edge_interval > win_cfg.zero_low) &&
                           (edge_interval < win_cfg.bit_split);
    end

endmodule

`default_nettype wire

/* design/irpd_frame.sv */
// ----------------------------------------------------------------------------
// irpd_frame
// frame state, bit shifter, complement check and motor drive states
// ----------------------------------------------------------------------------
`default_nettype none

module irpd_frame import irpd_pkg::*; #(
    parameter int FRAME_BITS = 32
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     step_en,
    input  wire win_hit_t win_hit,
    output result_t       result
);

    localparam int CNT_BITS = $clog2(FRAME_BITS + 1);
    localparam int CNT_W    = (CNT_BITS > 5) ? CNT_BITS : 5;

    logic             receiving_reg, receiving_next;
    logic [CNT_W-1:0] bit_count_reg, bit_count_next;
    logic [3:0][7:0]  bytes_reg, bytes_next;
    drive_t           left_reg, left_next;
    drive_t           right_reg, right_next;

    logic             shift_bit;
    logic [1:0]       byte_idx;
    logic [CNT_W-1:0] count_inc;
    logic             done;
    logic             ok;

    // shift, count and frame close
    always_comb begin
        shift_bit      = receiving_reg && !win_hit.is_start &&
                         (win_hit.is_one || win_hit.is_zero);
        byte_idx       = bit_count_reg[4:3];
        count_inc      = bit_count_reg + 1'b1;
        bytes_next     = bytes_reg;
        if (shift_bit) begin
            bytes_next[byte_idx] = {win_hit.is_one, bytes_reg[byte_idx][7:1]};
        end
        done           = shift_bit && (count_inc == CNT_W'(FRAME_BITS));
        ok             = done && (bytes_next[3] == ~bytes_next[2]);
        receiving_next = receiving_reg;
        bit_count_next = bit_count_reg;
        if (win_hit.is_start) begin
            receiving_next = 1'b1;
            bit_count_next = '0;
        end else if (done) begin
            receiving_next = 1'b0;
            bit_count_next = '0;
        end else if (shift_bit) begin
            bit_count_next = count_inc;
        end
    end

    // key decode on a frame that passed the check
    always_comb begin
        left_next  = left_reg;
        right_next = right_reg;
        if (ok) begin
            case (bytes_next[2])
                CMD_FORWARD: begin
                    left_next  = DRV_FWD;
                    right_next = DRV_FWD;
                end
                CMD_REVERSE: begin
                    left_next  = DRV_REV;
                    right_next = DRV_REV;
                end
                CMD_TURN_LEFT: begin
                    left_next  = DRV_STOP;
                    right_next = DRV_FWD;
                end
                CMD_TURN_RIGHT: begin
                    left_next  = DRV_FWD;
                    right_next = DRV_STOP;
                end
                CMD_STOP: begin
                    left_next  = DRV_STOP;
                    right_next = DRV_STOP;
                end
                default: begin
                    left_next  = left_reg;
                    right_next = right_reg;
                end
            endcase
        end
    end

    // result of this step
    always_comb begin
        result.frame_done   = done;
        result.frame_ok     = ok;
        result.address_word = done ? {bytes_next[1], bytes_next[0]} : 16'd0;
        result.command_byte = done ? bytes_next[2] : 8'd0;
        result.left_drive   = left_next;
        result.right_drive  = right_next;
    end

    // state update once per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            receiving_reg <= 1'b0;
            bit_count_reg <= '0;
            bytes_reg     <= '0;
            left_reg      <= DRV_STOP;
            right_reg     <= DRV_STOP;
        end else if (step_en) begin
            receiving_reg <= receiving_next;
            bit_count_reg <= bit_count_next;
            bytes_reg     <= bytes_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
        end
    end

endmodule

`default_nettype wire

/* design/ir_pulse_distance_decoder_core.sv */
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder_core
// decodes pulse distance ir frames from falling edge intervals and drives
// the two motor states from the key code
//
//  channel  dir  signals                       content
//  s_       in   s_tvalid s_tready s_tdata     edge interval, one item each
//  m_       out  m_tvalid m_tready m_tdata     one result item per input item
//                m_tuser
//  cfg_     in   cfg_valid cfg_ready cfg_index window bound register write
//                cfg_data
//
// every item passes from acceptance to result through the input register,
// one pass of compare and shift logic and the result register
// a new item is taken every cycle while the result side keeps up
// reset clears frame state and motor states and loads the bounds with their reset values
// a stall on m_ holds the result; an empty input register still takes one more
// item before s_tready drops
// ----------------------------------------------------------------------------
`default_nettype none

`include "ir_pulse_distance_decoder_core_defines.svh"

module ir_pulse_distance_decoder_core import irpd_pkg::*; #(
    parameter int FRAME_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // bits 15:0 edge_interval
    input  wire logic [15:0] s_tdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // bits 15:0 address_word, 23:16 command_byte, 25:24 left_drive,
    // 27:26 right_drive, 31:28 zero
    output logic [31:0]      m_tdata,
    // bit 0 frame_done, bit 1 frame_ok
    output logic [1:0]       m_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    win_cfg_t    win_cfg_reg;
    logic        in_vld_reg;
    logic [15:0] in_data_reg;
    logic        out_vld_reg;
    result_t     out_data_reg;

    logic        advance;
    win_hit_t    win_hit;
    result_t     step_result;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_cfg_reg.start_low  <= START_LOW_RST;
            win_cfg_reg.start_high <= START_HIGH_RST;
            win_cfg_reg.zero_low   <= ZERO_LOW_RST;
            win_cfg_reg.bit_split  <= BIT_SPLIT_RST;
            win_cfg_reg.one_high   <= ONE_HIGH_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_START_LOW:  win_cfg_reg.start_low  <= cfg_data;
                REG_START_HIGH: win_cfg_reg.start_high <= cfg_data;
                REG_ZERO_LOW:   win_cfg_reg.zero_low   <= cfg_data;
                REG_BIT_SPLIT:  win_cfg_reg.bit_split  <= cfg_data;
                REG_ONE_HIGH:   win_cfg_reg.one_high   <= cfg_data;
                default: ;
            endcase
        end
    end

    // item moves from the input register to the result register
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
    end

    irpd_window u_window (
        .edge_interval (in_data_reg),
        .win_cfg       (win_cfg_reg),
        .win_hit       (win_hit)
    );

    irpd_frame #(
        .FRAME_BITS (FRAME_BITS)
    ) u_frame (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .win_hit (win_hit),
        .result  (step_result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = {out_data_reg.frame_ok, out_data_reg.frame_done};
    assign m_tdata  = {4'd0, out_data_reg.right_drive, out_data_reg.left_drive,
                       out_data_reg.command_byte, out_data_reg.address_word};

    // checks
    `IRPD_ASSERT_RST(a_reset_empties_output, !aresetn |=> !m_tvalid, "result valid after reset")
    `IRPD_ASSERT(a_advance_fills_output, advance |=> m_tvalid, "advanced item not shown")
    `IRPD_ASSERT(a_idle_frame_fields_zero, m_tvalid && !m_tuser[0] |-> !m_tuser[1] && m_tdata[23:0] == 24'd0, "frame fields set without frame")
    `IRPD_ASSERT(a_drive_codes_legal, m_tvalid |-> m_tdata[25:24] != 2'd3 && m_tdata[27:26] != 2'd3, "illegal drive code")

endmodule

`default_nettype wire
